/* hdl/snms_pkg.sv */
// ----------------------------------------------------------------------------
// snms_pkg
// Shared constants, codes and stage records of the Sobel / non-maximum
// suppression pipeline.
// ----------------------------------------------------------------------------
package snms_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LINE_AW    = COL_W + 1;
  localparam int WIDTH_W    = COL_W + 1;
  localparam int HEIGHT_W   = 16;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 7;
  localparam int SQ_W       = 2 * GRAD_W + 1;
  localparam int ROOT_W     = SQ_W + 1;
  localparam int SQRT_HALF  = (PIX_W + 1) / 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_WIDTH_BITS = 11;

  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;
  localparam int THRESHOLD_RESET = 20;
  localparam int MIN_SIZE        = 3;

  localparam int TAN_LO_Q8 = 106;
  localparam int TAN_HI_Q8 = 618;
  localparam int TAN_W     = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH     = 2'd0,
    REG_HEIGHT    = 2'd1,
    REG_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_HORZ    = 2'd0,
    DIR_DIAG_UR = 2'd1,
    DIR_VERT    = 2'd2,
    DIR_DIAG_UL = 2'd3
  } dir_t;

  typedef struct packed {
    logic             sobel_on;
    logic             mag_on;
    logic             out_on;
    logic             last;
    logic             nms_on;
    logic             row_odd;
    logic [COL_W-1:0] col;
  } pos_t;

  typedef struct packed {
    logic              live;
    pos_t              pos;
    logic [GRAD_W-1:0] ax;
    logic [GRAD_W-1:0] ay;
    logic              same_sign;
  } grad_t;

  typedef struct packed {
    logic             live;
    pos_t             pos;
    logic [PIX_W-1:0] mag;
    dir_t             dir;
  } mag_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             out_valid;
    logic             last_pixel;
  } out_t;

  typedef struct packed {
    dir_t             dir;
    logic [PIX_W-1:0] mag;
  } mline_t;

  // one digit of the bit-pair square root; step 0 handles the top pair
  function automatic sqrt_t sqrt_step(input sqrt_t s, input int step);
    logic [ROOT_W-1:0] bitv;
    logic [ROOT_W-1:0] trial;
    sqrt_t             r;
    bitv  = ROOT_W'(1) << (2 * ((SQ_W - 1) / 2) - 2 * step);
    trial = s.root + bitv;
    r     = s;
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - SQ_W'(trial);
      r.root = (s.root >> 1) + bitv;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

/* hdl/snms_ifs.sv */
// ----------------------------------------------------------------------------
// snms channel interfaces
// Pixel input, edge output and register write channels.
// ----------------------------------------------------------------------------
interface snms_pix_if;
  logic                         valid;
  logic                         ready;
  logic [snms_pkg::PIX_W-1:0]   pixel;
  logic                         filler;
  modport source (output valid, output pixel, output filler, input ready);
  modport sink   (input valid, input pixel, input filler, output ready);
endinterface

interface snms_edge_if;
  logic                         valid;
  logic                         ready;
  logic [snms_pkg::PIX_W-1:0]   edge_value;
  logic                         out_valid;
  logic                         last_pixel;
  modport source (output valid, output edge_value, output out_valid, output last_pixel,
                  input ready);
  modport sink   (input valid, input edge_value, input out_valid, input last_pixel,
                  output ready);
endinterface

interface snms_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [snms_pkg::CFG_IDX_W-1:0]    index;
  logic [snms_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/snms_window.sv */
// ----------------------------------------------------------------------------
// snms_window
// Raster position, pixel line memory, 3x3 window and Sobel sums.
// ----------------------------------------------------------------------------
module snms_window (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             take,
  input  logic [snms_pkg::PIX_W-1:0]       pixel,
  input  logic                             filler,
  input  logic [snms_pkg::WIDTH_W-1:0]     width,
  input  logic [snms_pkg::HEIGHT_W-1:0]    height,
  input  logic                             restart,
  output snms_pkg::grad_t                  grad
);

  logic [snms_pkg::COL_W-1:0]   col;
  logic [snms_pkg::ROW_W-1:0]   row;
  logic [snms_pkg::COL_W-1:0]   col_next;
  logic [snms_pkg::ROW_W-1:0]   row_next;
  logic [snms_pkg::ROW_W-1:0]   h17;
  logic [snms_pkg::WIDTH_W-1:0] col_inc;
  logic [snms_pkg::PIX_W-1:0]   pix0;
  snms_pkg::pos_t               pos0;
  logic                         hi_col;

  logic [snms_pkg::PIX_W-1:0]   pix_mem [2*snms_pkg::MAX_WIDTH];
  logic [snms_pkg::PIX_W-1:0]   top_q;
  logic [snms_pkg::PIX_W-1:0]   mid_q;

  logic                         s1_live;
  logic [snms_pkg::PIX_W-1:0]   s1_pix;
  snms_pkg::pos_t               s1_pos;
  logic                         s2_live;
  snms_pkg::pos_t               s2_pos;
  logic [snms_pkg::PIX_W-1:0]   win [9];

  logic [10:0] px, nx, py, ny;
  logic [10:0] dx, dy;
  snms_pkg::grad_t              grad_next;

  always_comb begin
    h17     = {1'b0, height};
    hi_col  = col >= snms_pkg::COL_W'(2);
    pix0    = (row < h17 && !filler) ? pixel : '0;
    pos0.sobel_on = row >= snms_pkg::ROW_W'(2) && row <= h17 - 1'b1 && hi_col;
    pos0.mag_on   = row != '0 && col != '0;
    pos0.out_on   = hi_col ? row >= snms_pkg::ROW_W'(2) : row >= snms_pkg::ROW_W'(3);
    pos0.nms_on   = (col >= snms_pkg::COL_W'(3) || col == '0) &&
                    (hi_col ? (row >= snms_pkg::ROW_W'(3) && row <= h17)
                            : (row >= snms_pkg::ROW_W'(4) && row <= h17 + 1'b1));
    pos0.last     = col == snms_pkg::COL_W'(1) && row == h17 + snms_pkg::ROW_W'(2);
    pos0.row_odd  = row[0];
    pos0.col      = col;
    col_inc = {1'b0, col} + 1'b1;
    if (pos0.last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= width) begin
      col_next = '0;
      row_next = row + 1'b1;
    end else begin
      col_next = snms_pkg::COL_W'(col_inc);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (take) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // line pair: slot of the current row holds two rows back, the other one row back
  always_ff @(posedge clk) begin
    if (take) begin
      top_q <= pix_mem[{row[0], col}];
      mid_q <= pix_mem[{~row[0], col}];
      pix_mem[{row[0], col}] <= pix0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_live <= 1'b0;
      s2_live <= 1'b0;
    end else if (en) begin
      s1_live <= take;
      s2_live <= s1_live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix <= pix0;
      s1_pos <= pos0;
      s2_pos <= s1_pos;
      if (s1_live) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3]   <= win[k*3+1];
          win[k*3+1] <= win[k*3+2];
        end
        win[2] <= top_q;
        win[5] <= mid_q;
        win[8] <= s1_pix;
      end
    end
  end

  always_comb begin
    px = 11'(win[2]) + {2'b0, win[5], 1'b0} + 11'(win[8]);
    nx = 11'(win[0]) + {2'b0, win[3], 1'b0} + 11'(win[6]);
    py = 11'(win[6]) + {2'b0, win[7], 1'b0} + 11'(win[8]);
    ny = 11'(win[0]) + {2'b0, win[1], 1'b0} + 11'(win[2]);
    dx = (px >= nx) ? px - nx : nx - px;
    dy = (py >= ny) ? py - ny : ny - py;
    grad_next.live      = s2_live;
    grad_next.pos       = s2_pos;
    grad_next.ax        = s2_pos.sobel_on ? dx[9:3] : '0;
    grad_next.ay        = s2_pos.sobel_on ? dy[9:3] : '0;
    grad_next.same_sign = (px < nx) == (py < ny);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grad.live <= 1'b0;
    end else if (en) begin
      grad.live <= grad_next.live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grad.pos       <= grad_next.pos;
      grad.ax        <= grad_next.ax;
      grad.ay        <= grad_next.ay;
      grad.same_sign <= grad_next.same_sign;
    end
  end

endmodule

/* hdl/snms_grad.sv */
// ----------------------------------------------------------------------------
// snms_grad
// Squared magnitude, direction bin and two-stage integer square root.
// ----------------------------------------------------------------------------
module snms_grad (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  snms_pkg::grad_t  grad,
  output snms_pkg::mag_t   mag
);

  logic                          s4_live, s5_live;
  snms_pkg::pos_t                s4_pos, s5_pos;
  snms_pkg::dir_t                s4_dir, s5_dir, dir_next;
  logic [snms_pkg::SQ_W-1:0]     s4_sq;
  snms_pkg::sqrt_t               s5_sq;
  snms_pkg::sqrt_t               sa, sb;
  logic [snms_pkg::TAN_W-1:0]    ay_q8, lo_ref, hi_ref;

  always_comb begin
    ay_q8  = snms_pkg::TAN_W'({grad.ay, 8'd0});
    lo_ref = snms_pkg::TAN_W'(grad.ax) * snms_pkg::TAN_W'(snms_pkg::TAN_LO_Q8);
    hi_ref = snms_pkg::TAN_W'(grad.ax) * snms_pkg::TAN_W'(snms_pkg::TAN_HI_Q8);
    if (!grad.pos.sobel_on) begin
      dir_next = snms_pkg::DIR_HORZ;
    end else if (grad.ax == '0) begin
      dir_next = snms_pkg::DIR_VERT;
    end else if (ay_q8 <= lo_ref) begin
      dir_next = snms_pkg::DIR_HORZ;
    end else if (ay_q8 > hi_ref) begin
      dir_next = snms_pkg::DIR_VERT;
    end else begin
      dir_next = grad.same_sign ? snms_pkg::DIR_DIAG_UL : snms_pkg::DIR_DIAG_UR;
    end
  end

  always_comb begin
    sa.rem  = s4_sq;
    sa.root = '0;
    for (int k = 0; k < snms_pkg::SQRT_HALF; k++) begin
      sa = snms_pkg::sqrt_step(sa, k);
    end
    sb = s5_sq;
    for (int k = snms_pkg::SQRT_HALF; k < snms_pkg::PIX_W; k++) begin
      sb = snms_pkg::sqrt_step(sb, k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_live  <= 1'b0;
      s5_live  <= 1'b0;
      mag.live <= 1'b0;
    end else if (en) begin
      s4_live  <= grad.live;
      s5_live  <= s4_live;
      mag.live <= s5_live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pos  <= grad.pos;
      s4_dir  <= dir_next;
      s4_sq   <= snms_pkg::SQ_W'(grad.ax) * snms_pkg::SQ_W'(grad.ax) +
                 snms_pkg::SQ_W'(grad.ay) * snms_pkg::SQ_W'(grad.ay);
      s5_pos  <= s4_pos;
      s5_dir  <= s4_dir;
      s5_sq   <= sa;
      mag.pos <= s5_pos;
      mag.dir <= s5_dir;
      mag.mag <= snms_pkg::PIX_W'(sb.root);
    end
  end

endmodule

/* hdl/snms_nms.sv */
// ----------------------------------------------------------------------------
// snms_nms
// Magnitude/direction line memory, 3x3 magnitude window, suppression and
// two-word output queue.
// ----------------------------------------------------------------------------
module snms_nms (
  input  logic                         clk,
  input  logic                         rst,
  input  snms_pkg::mag_t               mag,
  input  logic [snms_pkg::PIX_W-1:0]   threshold,
  output logic                         en,
  output logic                         out_live,
  output snms_pkg::out_t               out_word,
  input  logic                         out_ready
);

  snms_pkg::mline_t              line_mem [2*snms_pkg::MAX_WIDTH];
  snms_pkg::mline_t              rd0, rd1;
  logic [snms_pkg::COL_W-1:0]    cc;

  logic                          s7_live, s8_live;
  snms_pkg::pos_t                s7_pos, s8_pos;
  logic [snms_pkg::PIX_W-1:0]    s7_mag;
  logic [snms_pkg::PIX_W-1:0]    mwin [9];
  snms_pkg::dir_t                dwin [3];

  logic [snms_pkg::PIX_W-1:0]    cen, na, nb;
  snms_pkg::out_t                res;

  snms_pkg::out_t                queue [2];
  logic [1:0]                    cnt;
  logic                          wptr, rptr;
  logic                          push, pop;

  assign cc = mag.pos.col - 1'b1;

  // slot of row-1 holds three rows back, the other slot two rows back
  always_ff @(posedge clk) begin
    if (en && mag.live && mag.pos.mag_on) begin
      rd0 <= line_mem[{~mag.pos.row_odd, cc}];
      rd1 <= line_mem[{mag.pos.row_odd, cc}];
      line_mem[{~mag.pos.row_odd, cc}] <= '{dir: mag.dir, mag: mag.mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_live <= 1'b0;
      s8_live <= 1'b0;
    end else if (en) begin
      s7_live <= mag.live;
      s8_live <= s7_live;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_pos <= mag.pos;
      s7_mag <= mag.mag;
      s8_pos <= s7_pos;
      if (s7_live) begin
        for (int k = 0; k < 3; k++) begin
          mwin[k*3]   <= mwin[k*3+1];
          mwin[k*3+1] <= mwin[k*3+2];
        end
        mwin[2] <= s7_pos.mag_on ? rd0.mag : '0;
        mwin[5] <= s7_pos.mag_on ? rd1.mag : '0;
        mwin[8] <= s7_mag;
        dwin[0] <= dwin[1];
        dwin[1] <= dwin[2];
        dwin[2] <= s7_pos.mag_on ? rd1.dir : snms_pkg::DIR_HORZ;
      end
    end
  end

  always_comb begin
    cen = mwin[4];
    case (dwin[1])
      snms_pkg::DIR_HORZ: begin
        na = mwin[3];
        nb = mwin[5];
      end
      snms_pkg::DIR_DIAG_UR: begin
        na = mwin[2];
        nb = mwin[6];
      end
      snms_pkg::DIR_VERT: begin
        na = mwin[1];
        nb = mwin[7];
      end
      default: begin
        na = mwin[0];
        nb = mwin[8];
      end
    endcase
    res.edge_value = (s8_pos.nms_on && cen > threshold && na <= cen && nb <= cen) ? cen : '0;
    res.out_valid  = s8_pos.out_on;
    res.last_pixel = s8_pos.last;
  end

  assign en       = cnt != 2'd2;
  assign push     = en && s8_live;
  assign out_live = cnt != 2'd0;
  assign pop      = out_live && out_ready;
  assign out_word = queue[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hdl/sobel_nonmax_suppression_top.sv */
// ----------------------------------------------------------------------------
// sobel_nonmax_suppression_top
// Sobel gradient, direction binning and non-maximum suppression over a
// raster pixel stream.
//
//   channel | dir | word
//   pixels  | in  | pixel, filler
//   edges   | out | edge_value, out_valid, last_pixel
//   cfg     | in  | index, data (0 width, 1 height, 2 threshold)
//
// One word per clock sustained while the output queue is not full.
// Each result describes the position two rows plus two columns behind.
// The pipeline freezes only while its two-word output queue is full.
// Reset clears control state only; line memories are never cleared, every
// entry is rewritten within a frame before it can reach a result.
// ----------------------------------------------------------------------------
module sobel_nonmax_suppression_top (
  input  logic        clk,
  input  logic        rst,
  snms_pix_if.sink    pixels,
  snms_edge_if.source edges,
  snms_cfg_if.sink    cfg
);

  logic [snms_pkg::WIDTH_W-1:0]  width;
  logic [snms_pkg::HEIGHT_W-1:0] height;
  logic [snms_pkg::PIX_W-1:0]    threshold;
  logic [snms_pkg::CFG_WIDTH_BITS-1:0] raw_w;
  logic                          cfg_wr, restart, en, take;
  snms_pkg::grad_t               grad;
  snms_pkg::mag_t                mag;
  snms_pkg::out_t                out_word;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign raw_w     = cfg.data[snms_pkg::CFG_WIDTH_BITS-1:0];
  assign restart   = cfg_wr && (cfg.index == snms_pkg::REG_WIDTH ||
                                cfg.index == snms_pkg::REG_HEIGHT ||
                                cfg.index == snms_pkg::REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= snms_pkg::WIDTH_W'(snms_pkg::WIDTH_RESET);
      height    <= snms_pkg::HEIGHT_W'(snms_pkg::HEIGHT_RESET);
      threshold <= snms_pkg::PIX_W'(snms_pkg::THRESHOLD_RESET);
    end else if (cfg_wr) begin
      case (cfg.index)
        snms_pkg::REG_WIDTH: begin
          if (int'(raw_w) < snms_pkg::MIN_SIZE) begin
            width <= snms_pkg::WIDTH_W'(snms_pkg::MIN_SIZE);
          end else if (int'(raw_w) > snms_pkg::MAX_WIDTH) begin
            width <= snms_pkg::WIDTH_W'(snms_pkg::MAX_WIDTH);
          end else begin
            width <= snms_pkg::WIDTH_W'(raw_w);
          end
        end
        snms_pkg::REG_HEIGHT: begin
          height <= (int'(cfg.data) < snms_pkg::MIN_SIZE) ?
                    snms_pkg::HEIGHT_W'(snms_pkg::MIN_SIZE) : cfg.data;
        end
        snms_pkg::REG_THRESHOLD: begin
          threshold <= cfg.data[snms_pkg::PIX_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign pixels.ready = en;
  assign take         = pixels.valid && en;

  snms_window u_window (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .take    (take),
    .pixel   (pixels.pixel),
    .filler  (pixels.filler),
    .width   (width),
    .height  (height),
    .restart (restart),
    .grad    (grad)
  );

  snms_grad u_grad (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .grad (grad),
    .mag  (mag)
  );

  snms_nms u_nms (
    .clk       (clk),
    .rst       (rst),
    .mag       (mag),
    .threshold (threshold),
    .en        (en),
    .out_live  (edges.valid),
    .out_word  (out_word),
    .out_ready (edges.ready)
  );

  assign edges.edge_value = out_word.edge_value;
  assign edges.out_valid  = out_word.out_valid;
  assign edges.last_pixel = out_word.last_pixel;

endmodule

/* hdl/snms_checker.sv */
// ----------------------------------------------------------------------------
// snms_checker
// Port-level checks on the edge pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module snms_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_vld,
  input logic                       out_rdy,
  input logic [snms_pkg::PIX_W-1:0] edge_value,
  input logic                       out_valid,
  input logic                       last_pixel
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_rdy |=> out_vld)
    else $error("output word dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_rdy |=> $stable(edge_value) && $stable(out_valid) && $stable(last_pixel))
    else $error("output word changed while stalled");

  a_edge_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> edge_value == '0 || out_valid)
    else $error("nonzero edge outside frame");

  a_last_in_frame: assert property (@(posedge clk) disable iff (rst)
    out_vld && last_pixel |-> out_valid)
    else $error("frame end outside frame");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind sobel_nonmax_suppression_top snms_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixels.ready),
  .out_vld    (edges.valid),
  .out_rdy    (edges.ready),
  .edge_value (edges.edge_value),
  .out_valid  (edges.out_valid),
  .last_pixel (edges.last_pixel)
);
